FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the escape-time iterator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define AST_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked on clk, off during reset
`define AST_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/fti_pkg.sv
// Types, constants and helpers for the escape-time iterator
`default_nettype none
package fti_pkg;

  localparam int VAL_W    = 63;
  localparam int MAG_W    = 62;
  localparam int MAGOUT_W = 48;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic [1:0]              phase_t;

  localparam phase_t PH_CARD0 = 2'd0;
  localparam phase_t PH_CARD1 = 2'd1;
  localparam phase_t PH_ITER  = 2'd2;
  localparam phase_t PH_DONE  = 2'd3;

  localparam logic [2:0] CFG_LIMIT  = 3'd0;
  localparam logic [2:0] CFG_JULIA  = 3'd1;
  localparam logic [2:0] CFG_SHIP   = 3'd2;
  localparam logic [2:0] CFG_INNER  = 3'd3;
  localparam logic [2:0] CFG_SEED_R = 3'd4;
  localparam logic [2:0] CFG_SEED_I = 3'd5;

  localparam logic signed [63:0] SAT_POS = 64'sd1 <<< 61;
  localparam logic signed [63:0] SAT_NEG = -(64'sd1 <<< 61);

  typedef struct packed {
    logic [15:0]        limit;
    logic               julia;
    logic               ship;
    logic               inner;
    logic signed [31:0] seed_r;
    logic signed [31:0] seed_i;
  } cfg_t;

  typedef struct packed {
    phase_t                phase;
    val_t                  u;
    val_t                  v;
    val_t                  w;
    logic signed [31:0]    cr;
    logic signed [31:0]    ci;
    logic                  in_set;
    logic [MAGOUT_W-1:0]   res_mag;
  } slot_t;

  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    if (s > SAT_POS) return val_t'(SAT_POS);
    if (s < SAT_NEG) return val_t'(SAT_NEG);
    return val_t'(s);
  endfunction

  function automatic mag_t abs_mag(val_t a);
    val_t n;
    n = -a;
    return a[VAL_W-1] ? n[MAG_W-1:0] : a[MAG_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/escape_time_fractal_iterator.sv
// Top level: escape-time iterator ring with in-order result register
// Each point circulates round a seven-stage ring (operand select, four multiplier
// stages, two sum/update stages) and makes one iteration per pass. In plain
// Mandelbrot mode two passes for the cardioid and bulb test come first (a point
// judged inside there leaves after the first or second). Up to seven points share
// the ring; a new point enters only a slot that comes round empty or retiring.
// Results leave in input order; a finished point keeps circulating until the
// points ahead of it have been transferred, and output stalls add to the time.
// No clearing pass after reset.
`default_nettype none
module escape_time_fractal_iterator #(
  parameter int COORD_FRAC_BITS  = 28,
  parameter int ITER_WIDTH       = 16,
  parameter int ESCAPE_RADIUS_SQ = 10000
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire signed [31:0]  in_point_real,
  input  wire signed [31:0]  in_point_imag,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [15:0]        out_iteration_count,
  output logic               out_inside_flag,
  output logic [47:0]        out_final_magnitude_sq,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [2:0]          cfg_index,
  input  wire [31:0]         cfg_data
);
  import fti_pkg::*;

  `include "assert_macros.svh"

  localparam int   RING  = 7;
  localparam int   DLY   = 4;
  localparam int   SEQ_W = $clog2(RING + 1);
  localparam val_t ONE   = val_t'(64'd1 << COORD_FRAC_BITS);
  localparam val_t QRT   = val_t'(64'd1 << (COORD_FRAC_BITS - 2));

  cfg_t cfg_r;

  logic [SEQ_W-1:0] iseq_r, oseq_r;

  logic              v7;
  slot_t             slot7;
  logic [ITER_WIDTH-1:0] cnt7;
  logic [SEQ_W-1:0]  seq7;

  logic retire, recirc, take, card;
  slot_t new_slot, slot_in;
  logic [ITER_WIDTH-1:0] cnt_in;
  logic [SEQ_W-1:0]  seq_in;
  val_t pr, pi, oa [3], ob [3];

  logic              v1_r;
  slot_t             slot1_r;
  logic [ITER_WIDTH-1:0] cnt1_r;
  logic [SEQ_W-1:0]  seq1_r;
  mag_t              am_r [3], bm_r [3];
  logic              ng_r [3];

  logic              vd_r    [DLY];
  slot_t             slotd_r [DLY];
  logic [ITER_WIDTH-1:0] cntd_r [DLY];
  logic [SEQ_W-1:0]  seqd_r  [DLY];

  val_t              m [3];

  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_cnt_r;
  logic              out_in_r;
  logic [47:0]       out_mag_r;

  // configuration
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit  <= 16'd128;
      cfg_r.julia  <= 1'b0;
      cfg_r.ship   <= 1'b0;
      cfg_r.inner  <= 1'b0;
      cfg_r.seed_r <= -32'sd214748365;
      cfg_r.seed_i <= 32'sd41875931;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LIMIT:  cfg_r.limit  <= cfg_data[15:0];
        CFG_JULIA:  cfg_r.julia  <= cfg_data[0];
        CFG_SHIP:   cfg_r.ship   <= cfg_data[0];
        CFG_INNER:  cfg_r.inner  <= cfg_data[0];
        CFG_SEED_R: cfg_r.seed_r <= cfg_data;
        CFG_SEED_I: cfg_r.seed_i <= cfg_data;
        default: ;
      endcase
    end
  end

  // ring entry
  assign retire   = v7 && (slot7.phase == PH_DONE) && (seq7 == oseq_r)
                    && (!out_valid_r || out_ready);
  assign recirc   = v7 && !retire;
  assign in_ready = !recirc;
  assign take     = in_valid && in_ready;

  assign pr   = val_t'(in_point_real);
  assign pi   = val_t'(in_point_imag);
  assign card = !cfg_r.julia && !cfg_r.inner && !cfg_r.ship;

  always_comb begin
    new_slot.phase   = (!cfg_r.julia && card) ? PH_CARD0 : PH_ITER;
    new_slot.u       = cfg_r.julia ? pr : (card ? sat_add(pr, val_t'(-QRT)) : '0);
    new_slot.v       = (cfg_r.julia || card) ? pi : '0;
    new_slot.w       = sat_add(pr, ONE);
    new_slot.cr      = cfg_r.julia ? cfg_r.seed_r : in_point_real;
    new_slot.ci      = cfg_r.julia ? cfg_r.seed_i : in_point_imag;
    new_slot.in_set  = 1'b0;
    new_slot.res_mag = '0;
  end

  assign slot_in = recirc ? slot7 : new_slot;
  assign cnt_in  = recirc ? cnt7  : '0;
  assign seq_in  = recirc ? seq7  : iseq_r;

  always_comb begin
    oa[0] = slot_in.u;
    ob[0] = slot_in.u;
    oa[1] = slot_in.v;
    ob[1] = slot_in.v;
    unique case (slot_in.phase)
      PH_CARD0: begin
        oa[2] = slot_in.w;
        ob[2] = slot_in.w;
      end
      PH_CARD1: begin
        oa[2] = slot_in.u;
        ob[2] = slot_in.w;
      end
      default: begin
        oa[2] = slot_in.u;
        ob[2] = slot_in.v;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      iseq_r <= '0;
      oseq_r <= '0;
    end else begin
      v1_r <= recirc || take;
      if (take)   iseq_r <= iseq_r + SEQ_W'(1);
      if (retire) oseq_r <= oseq_r + SEQ_W'(1);
    end
    slot1_r <= slot_in;
    cnt1_r  <= cnt_in;
    seq1_r  <= seq_in;
    for (int i = 0; i < 3; i++) begin
      am_r[i] <= abs_mag(oa[i]);
      bm_r[i] <= abs_mag(ob[i]);
      ng_r[i] <= oa[i][VAL_W-1] ^ ob[i][VAL_W-1];
    end
  end

  // slot state rides alongside the multipliers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DLY; i++) vd_r[i] <= 1'b0;
    end else begin
      vd_r[0] <= v1_r;
      for (int i = 1; i < DLY; i++) vd_r[i] <= vd_r[i-1];
    end
    slotd_r[0] <= slot1_r;
    cntd_r[0]  <= cnt1_r;
    seqd_r[0]  <= seq1_r;
    for (int i = 1; i < DLY; i++) begin
      slotd_r[i] <= slotd_r[i-1];
      cntd_r[i]  <= cntd_r[i-1];
      seqd_r[i]  <= seqd_r[i-1];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_mul
    fti_mul #(
      .FRAC (COORD_FRAC_BITS)
    ) u_mul (
      .clk   (clk),
      .a_mag (am_r[g]),
      .b_mag (bm_r[g]),
      .neg   (ng_r[g]),
      .prod  (m[g])
    );
  end

  fti_update #(
    .FRAC   (COORD_FRAC_BITS),
    .ESC_R  (ESCAPE_RADIUS_SQ),
    .ITER_W (ITER_WIDTH),
    .SEQ_W  (SEQ_W)
  ) u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .vld_in   (vd_r[DLY-1]),
    .slot_in  (slotd_r[DLY-1]),
    .cnt_in   (cntd_r[DLY-1]),
    .seq_in   (seqd_r[DLY-1]),
    .m0       (m[0]),
    .m1       (m[1]),
    .m2       (m[2]),
    .vld_out  (v7),
    .slot_out (slot7),
    .cnt_out  (cnt7),
    .seq_out  (seq7)
  );

  // result register
  assign out_valid_nxt = retire || (out_valid_r && !out_ready);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (retire) begin
      out_cnt_r <= 16'(cnt7);
      out_in_r  <= slot7.in_set;
      out_mag_r <= slot7.res_mag;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_iteration_count    = out_cnt_r;
  assign out_inside_flag        = out_in_r;
  assign out_final_magnitude_sq = out_mag_r;

  `AST_NXT(a_take_enters, take, v1_r)
  `AST_NXT(a_retire_loads, retire, out_valid_r)
  `AST_IMP(a_inside_zero, out_valid_r && out_inside_flag, (out_iteration_count == 16'd0) && (out_final_magnitude_sq == 48'd0))
  `AST_IMP(a_no_take_on_recirc, recirc, !take)

endmodule
`default_nettype wire

FILE: rtl/core/fti_mul.sv
// Four-stage saturating fixed-point multiplier, floor rounding
`default_nettype none
module fti_mul #(
  parameter int FRAC = 28
) (
  input  wire                 clk,
  input  wire fti_pkg::mag_t  a_mag,
  input  wire fti_pkg::mag_t  b_mag,
  input  wire                 neg,
  output fti_pkg::val_t       prod
);
  import fti_pkg::*;

  localparam int H  = MAG_W / 2;
  localparam int PW = 2 * MAG_W;
  localparam mag_t BOUND = mag_t'(1) << (MAG_W - 1);

  logic [MAG_W-1:0] ll_r, lh_r, hl_r, hh_r;
  logic [MAG_W-1:0] ll_nxt, lh_nxt, hl_nxt, hh_nxt;
  logic [MAG_W-1:0] ll3_r, hh3_r;
  logic [MAG_W:0]   cross_r, cross_nxt;
  logic [PW-1:0]    full_r, full_nxt;
  val_t             prod_r, prod_nxt;
  logic             neg2_r, neg3_r, neg4_r;

  logic [PW-1:0]    q;
  logic             rem, ovf;
  mag_t             mg;
  logic [MAG_W:0]   t;

  always_comb begin
    ll_nxt = a_mag[H-1:0]     * b_mag[H-1:0];
    lh_nxt = a_mag[H-1:0]     * b_mag[MAG_W-1:H];
    hl_nxt = a_mag[MAG_W-1:H] * b_mag[H-1:0];
    hh_nxt = a_mag[MAG_W-1:H] * b_mag[MAG_W-1:H];
  end

  assign cross_nxt = (MAG_W+1)'(lh_r) + (MAG_W+1)'(hl_r);
  assign full_nxt  = {hh3_r, ll3_r} + PW'({cross_r, H'(0)});

  always_comb begin
    q   = full_r >> FRAC;
    rem = |full_r[FRAC-1:0];
    ovf = (|q[PW-1:MAG_W]) || (q[MAG_W-1:0] > BOUND);
    mg  = ovf ? BOUND : q[MAG_W-1:0];
    t   = (MAG_W+1)'(mg) + (MAG_W+1)'(rem);
    if (t > (MAG_W+1)'(BOUND)) t = (MAG_W+1)'(BOUND);
    prod_nxt = neg4_r ? -val_t'(t) : val_t'(mg);
  end

  always_ff @(posedge clk) begin
    ll_r    <= ll_nxt;
    lh_r    <= lh_nxt;
    hl_r    <= hl_nxt;
    hh_r    <= hh_nxt;
    neg2_r  <= neg;
    ll3_r   <= ll_r;
    hh3_r   <= hh_r;
    cross_r <= cross_nxt;
    neg3_r  <= neg2_r;
    full_r  <= full_nxt;
    neg4_r  <= neg3_r;
    prod_r  <= prod_nxt;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

FILE: rtl/core/fti_update.sv
// Sum, escape test, cardioid/bulb test and state update stages of the iteration ring
`default_nettype none
module fti_update #(
  parameter int FRAC   = 28,
  parameter int ESC_R  = 10000,
  parameter int ITER_W = 16,
  parameter int SEQ_W  = 3
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire fti_pkg::cfg_t   cfg,
  input  wire                  vld_in,
  input  wire fti_pkg::slot_t  slot_in,
  input  wire [ITER_W-1:0]     cnt_in,
  input  wire [SEQ_W-1:0]      seq_in,
  input  wire fti_pkg::val_t   m0,
  input  wire fti_pkg::val_t   m1,
  input  wire fti_pkg::val_t   m2,
  output logic                 vld_out,
  output fti_pkg::slot_t       slot_out,
  output logic [ITER_W-1:0]    cnt_out,
  output logic [SEQ_W-1:0]     seq_out
);
  import fti_pkg::*;

  localparam logic [63:0] RB   = 64'd1 << (61 - FRAC);
  localparam val_t        THR  = (64'(ESC_R) > RB) ? val_t'(SAT_POS)
                                                   : val_t'(64'(ESC_R) << FRAC);
  localparam val_t        ONE4 = val_t'(64'd1 << (FRAC - 4));

  logic              v6_r, v7_r;
  slot_t             slot6_r, slot7_r, slot7_nxt;
  logic [ITER_W-1:0] cnt6_r, cnt7_r, cnt7_nxt;
  logic [SEQ_W-1:0]  seq6_r, seq7_r;
  val_t              m1_6_r, m2_6_r;
  val_t              sa_r, sb_r, sc_r, sd_r;
  val_t              sa_nxt, sb_nxt, sc_nxt, sd_nxt, pp;

  logic [ITER_W-1:0]   lim_m, lim_eff;
  logic [VAL_W-1:0]    mu;
  logic [MAGOUT_W-1:0] mag_o;

  always_comb begin
    pp     = (cfg.ship && m2[VAL_W-1]) ? val_t'(-m2) : m2;
    sa_nxt = sat_add(m0, m1);
    sb_nxt = sat_add(m0, val_t'(-m1));
    sc_nxt = sat_add(pp, pp);
    sd_nxt = sat_add(m2, m1);
  end

  assign lim_m   = ITER_W'(cfg.limit);
  assign lim_eff = (lim_m == '0) ? ITER_W'(1) : lim_m;
  assign mu      = VAL_W'(sa_r) >> (FRAC - 16);
  assign mag_o   = (|mu[VAL_W-1:MAGOUT_W]) ? '1 : mu[MAGOUT_W-1:0];

  always_comb begin
    slot7_nxt = slot6_r;
    cnt7_nxt  = cnt6_r;
    unique case (slot6_r.phase)
      PH_ITER: begin
        if (cnt6_r == lim_eff) begin
          slot7_nxt.phase = PH_DONE;
          if (cfg.inner) begin
            slot7_nxt.in_set  = 1'b0;
            slot7_nxt.res_mag = mag_o;
          end else begin
            slot7_nxt.in_set  = 1'b1;
            slot7_nxt.res_mag = '0;
            cnt7_nxt          = '0;
          end
        end else if (sa_r >= THR) begin
          slot7_nxt.phase   = PH_DONE;
          slot7_nxt.in_set  = 1'b0;
          slot7_nxt.res_mag = mag_o;
        end else begin
          slot7_nxt.u = sat_add(sb_r, val_t'(slot6_r.cr));
          slot7_nxt.v = sat_add(sc_r, val_t'(slot6_r.ci));
          cnt7_nxt    = cnt6_r + ITER_W'(1);
        end
      end
      PH_CARD0: begin
        if (sd_r < ONE4) begin
          slot7_nxt.phase   = PH_DONE;
          slot7_nxt.in_set  = 1'b1;
          slot7_nxt.res_mag = '0;
          cnt7_nxt          = '0;
        end else begin
          slot7_nxt.phase = PH_CARD1;
          slot7_nxt.u     = sa_r;
          slot7_nxt.v     = m1_6_r;
          slot7_nxt.w     = sat_add(sa_r, slot6_r.u);
        end
      end
      PH_CARD1: begin
        if (m2_6_r < (slot6_r.v >>> 2)) begin
          slot7_nxt.phase   = PH_DONE;
          slot7_nxt.in_set  = 1'b1;
          slot7_nxt.res_mag = '0;
          cnt7_nxt          = '0;
        end else begin
          slot7_nxt.phase = PH_ITER;
          slot7_nxt.u     = '0;
          slot7_nxt.v     = '0;
          cnt7_nxt        = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v6_r <= vld_in;
      v7_r <= v6_r;
    end
    slot6_r <= slot_in;
    cnt6_r  <= cnt_in;
    seq6_r  <= seq_in;
    m1_6_r  <= m1;
    m2_6_r  <= m2;
    sa_r    <= sa_nxt;
    sb_r    <= sb_nxt;
    sc_r    <= sc_nxt;
    sd_r    <= sd_nxt;
    slot7_r <= slot7_nxt;
    cnt7_r  <= cnt7_nxt;
    seq7_r  <= seq6_r;
  end

  assign vld_out  = v7_r;
  assign slot_out = slot7_r;
  assign cnt_out  = cnt7_r;
  assign seq_out  = seq7_r;

endmodule
`default_nettype wire
